/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define XTKQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define XTKQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define XTKQ_ASSERT(lbl, prop, msg)
`define XTKQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* hdl/xtkq_pkg.sv */
package xtkq_pkg;

  localparam int KEY_COUNT  = 70;
  localparam int FIFO_DEPTH = 16;

  localparam int KEY_W     = 7;
  localparam int CODE_W    = 8;
  localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  localparam logic [CODE_W-1:0] BREAK_BIT = 8'h80;

  typedef enum logic {
    CMD_KEY_SAMPLE = 1'b0,
    CMD_POLL       = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key_index;
    logic             key_held;
    logic             port_busy;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] scan_code;
    logic              raise_irq;
  } out_item_t;

  // Key change event from the key tracker.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } key_event_t;

  // Control broadcast to every cell of the code queue.
  typedef struct packed {
    logic push;
    logic pop;
  } chain_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } chain_stat_t;

  // Set-1 make codes. Keys 0 to 53 run consecutively from 0x01; the rest
  // skip codes of keys that this keyboard does not have.
  function automatic logic [CODE_W-1:0] make_code(input logic [KEY_W-1:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      7'd54:   c = 8'h38;
      7'd55:   c = 8'h39;
      7'd56:   c = 8'h3B;
      7'd57:   c = 8'h3C;
      7'd58:   c = 8'h3D;
      7'd59:   c = 8'h3E;
      7'd60:   c = 8'h3F;
      7'd61:   c = 8'h40;
      7'd62:   c = 8'h41;
      7'd63:   c = 8'h42;
      7'd64:   c = 8'h43;
      7'd65:   c = 8'h44;
      7'd66:   c = 8'h48;
      7'd67:   c = 8'h4B;
      7'd68:   c = 8'h4D;
      7'd69:   c = 8'h50;
      default: c = (idx < 7'd54) ? ({1'b0, idx} + 8'd1) : 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hdl/xtkq_cell.sv */
module xtkq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  xtkq_pkg::chain_ctrl_t     ctrl,
  input  logic [7:0]                push_code,
  input  logic                      prev_valid,
  input  logic                      next_valid,
  input  logic [7:0]                next_code,
  output logic                      valid,
  output logic [7:0]                code
);
  import xtkq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  // On a pop every cell takes its upstream neighbor. On a push the first
  // empty cell, the one whose downstream neighbor is filled, takes the code.
  always_comb begin
    valid_nxt = valid_r;
    code_nxt  = code_r;
    if (ctrl.pop) begin
      valid_nxt = next_valid;
      code_nxt  = next_code;
    end else if (ctrl.push && !valid_r && prev_valid) begin
      valid_nxt = 1'b1;
      code_nxt  = push_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign valid = valid_r;
  assign code  = code_r;

endmodule

/* hdl/xtkq_chain.sv */
`include "assert_macros.svh"

module xtkq_chain (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xtkq_pkg::chain_ctrl_t ctrl,
  input  logic [7:0]            push_code,
  output logic [7:0]            head_code,
  output xtkq_pkg::chain_stat_t stat
);
  import xtkq_pkg::*;

  logic [FIFO_DEPTH-1:0] valid_vec;
  logic [CODE_W-1:0]     code_arr [FIFO_DEPTH];
  logic [FIFO_DEPTH-1:0] prev_valid_vec;
  logic [FIFO_DEPTH-1:0] next_valid_vec;
  logic [CODE_W-1:0]     next_code_arr [FIFO_DEPTH];

  // Cell 0 is the head. Its downstream side always counts as filled, and the
  // last cell sees an empty upstream neighbor.
  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_valid_vec[i] = 1'b1;
    end else begin : g_mid
      assign prev_valid_vec[i] = valid_vec[i-1];
    end
    if (i == FIFO_DEPTH - 1) begin : g_last
      assign next_valid_vec[i] = 1'b0;
      assign next_code_arr[i]  = '0;
    end else begin : g_inner
      assign next_valid_vec[i] = valid_vec[i+1];
      assign next_code_arr[i]  = code_arr[i+1];
    end

    xtkq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .push_code  (push_code),
      .prev_valid (prev_valid_vec[i]),
      .next_valid (next_valid_vec[i]),
      .next_code  (next_code_arr[i]),
      .valid      (valid_vec[i]),
      .code       (code_arr[i])
    );
  end

  assign head_code  = code_arr[0];
  assign stat.empty = !valid_vec[0];
  assign stat.full  = valid_vec[FIFO_DEPTH-1];

  `XTKQ_ASSERT(a_packed_toward_head, ((valid_vec >> 1) & ~valid_vec) == '0, "queue has a gap")
  `XTKQ_ASSERT(a_no_pop_empty, ctrl.pop |-> valid_vec[0], "pop from an empty queue")
  `XTKQ_ASSERT(a_push_grows, ctrl.push && !ctrl.pop && !valid_vec[FIFO_DEPTH-1] |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1, "push not stored")
  `XTKQ_ASSERT(a_full_drops, ctrl.push && valid_vec[FIFO_DEPTH-1] |=> $stable(valid_vec), "push into full queue changed it")

endmodule

/* hdl/xtkq_key_tracker.sv */
module xtkq_key_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 sample,
  input  logic [6:0]           key_index,
  input  logic                 key_held,
  output xtkq_pkg::key_event_t evt
);
  import xtkq_pkg::*;

  logic [KEY_COUNT-1:0] held_r, held_nxt;
  logic                 in_range;
  logic [KEY_IDX_W-1:0] slot;
  logic                 was_held;
  logic                 changed;

  assign in_range = {1'b0, key_index} < 8'(KEY_COUNT);
  assign slot     = key_index[KEY_IDX_W-1:0];
  assign was_held = in_range ? held_r[slot] : 1'b0;
  assign changed  = sample && in_range && (was_held != key_held);

  always_comb begin
    held_nxt = held_r;
    if (changed) begin
      held_nxt[slot] = key_held;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  assign evt.valid = changed;
  assign evt.code  = make_code(key_index) | (key_held ? 8'h00 : BREAK_BIT);

endmodule

/* hdl/xt_keyboard_scancode_queue.sv */
// Channel  Ports                          Carries
// in       in_valid, in_ready, in_data    key sample or delivery poll request
// out      out_valid, out_ready, out_data delivered scan code with IRQ1 request
//
// A new request is taken in every cycle in which in_ready is high.
// in_ready drops only while a delivered code sits in the output register
// and out_ready is low, so the output register alone sets the pace.
// A delivered code appears on out_data the cycle after its poll is taken.
// Synchronous reset clears key state and the code queue at once.
`include "assert_macros.svh"

module xt_keyboard_scancode_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  xtkq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output xtkq_pkg::out_item_t out_data
);
  import xtkq_pkg::*;

  logic        accept;
  logic        sample;
  logic        poll_take;
  key_event_t  evt;
  chain_ctrl_t ctrl;
  chain_stat_t stat;
  logic [CODE_W-1:0] head_code;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign sample    = accept && (in_data.cmd == CMD_KEY_SAMPLE);
  assign poll_take = accept && (in_data.cmd == CMD_POLL) && !in_data.port_busy && !stat.empty;

  xtkq_key_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample    (sample),
    .key_index (in_data.key_index),
    .key_held  (in_data.key_held),
    .evt       (evt)
  );

  assign ctrl.push = evt.valid;
  assign ctrl.pop  = poll_take;

  xtkq_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .push_code (evt.code),
    .head_code (head_code),
    .stat      (stat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (poll_take) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.scan_code = head_code;
      out_data_nxt.raise_irq = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `XTKQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")
  `XTKQ_ASSERT(a_poll_delivers, poll_take |=> out_valid && out_data.raise_irq, "poll did not deliver")
  `XTKQ_ASSERT(a_no_mixed_ops, !(ctrl.push && ctrl.pop), "push and pop in one cycle")
  `XTKQ_ASSERT(a_full_not_empty, !(stat.full && stat.empty), "queue both full and empty")

endmodule

/* sim/xtkq_scoreboard.sv */
`timescale 1ns / 1ps

module xtkq_scoreboard (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  xtkq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  xtkq_pkg::out_item_t out_data,
  output int unsigned         mismatch_count,
  output int unsigned         codes_awaited
);

  import xtkq_pkg::*;

  // Set-1 make codes for keys 0 to 69, key 0 in the top byte.
  localparam logic [70*8-1:0] SET1_MAKE = {
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
    8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14,
    8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E,
    8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
    8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h4B, 8'h4D, 8'h50
  };

  bit                key_down [0:127];
  logic [CODE_W-1:0] queued_codes [$];
  out_item_t         due_codes [$];
  out_item_t         oldest_due;
  int unsigned       error_total;

  initial begin
    mismatch_count = 0;
    codes_awaited  = 0;
    error_total    = 0;
  end

  function automatic logic [CODE_W-1:0] set1_code(input logic [KEY_W-1:0] idx);
    int i;
    i = idx;
    // Indexes past the table, which ends at the key count, give make code zero.
    if (i < 70) return SET1_MAKE[(69 - i)*8 +: 8];
    return '0;
  endfunction

  task automatic track_request(input in_item_t req);
    logic [CODE_W-1:0] code;
    out_item_t         res;
    if (req.cmd == CMD_KEY_SAMPLE) begin
      if (req.key_index < KEY_COUNT && req.key_held != key_down[req.key_index]) begin
        key_down[req.key_index] = req.key_held;
        code = set1_code(req.key_index);
        if (!req.key_held) code = code | BREAK_BIT;
        // A full queue drops the code, but the key state still follows.
        if (queued_codes.size() < FIFO_DEPTH) queued_codes.push_back(code);
      end
    end else if (!req.port_busy && queued_codes.size() != 0) begin
      res.scan_code = queued_codes.pop_front();
      res.raise_irq = 1'b1;
      due_codes.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (key_down[i]) key_down[i] = 1'b0;
      queued_codes.delete();
      due_codes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_codes.size() == 0) begin
          error_total++;
          $display("%0t: unexpected result, expected none, got scan_code %h raise_irq %b",
                   $time, out_data.scan_code, out_data.raise_irq);
        end else begin
          oldest_due = due_codes.pop_front();
          if (out_data.scan_code !== oldest_due.scan_code) begin
            error_total++;
            $display("%0t: scan_code mismatch, expected %h, got %h",
                     $time, oldest_due.scan_code, out_data.scan_code);
          end
          if (out_data.raise_irq !== oldest_due.raise_irq) begin
            error_total++;
            $display("%0t: raise_irq mismatch, expected %b, got %b",
                     $time, oldest_due.raise_irq, out_data.raise_irq);
          end
        end
      end
      if (in_valid && in_ready) track_request(in_data);
    end
    mismatch_count <= error_total;
    codes_awaited  <= due_codes.size();
  end

endmodule

/* sim/tb_xt_keyboard_scancode_queue.sv */
`timescale 1ns / 1ps

module tb_xt_keyboard_scancode_queue;

  import xtkq_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 375;

  typedef enum int {
    TRAFFIC_MIXED,
    TRAFFIC_TYPING,
    TRAFFIC_DRAIN
  } traffic_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  int unsigned mismatch_count;
  int unsigned codes_awaited;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          quiet_cycles = 0;

  xt_keyboard_scancode_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  xtkq_scoreboard scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .codes_awaited  (codes_awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t make_request(input cmd_t cmd, input int idx,
                                            input bit held, input bit busy);
    in_item_t req;
    req.cmd       = cmd;
    req.key_index = idx[KEY_W-1:0];
    req.key_held  = held;
    req.port_busy = busy;
    return req;
  endfunction

  function automatic in_item_t random_request(input traffic_t style);
    int   poll_pct;
    int   busy_pct;
    int   idx;
    cmd_t cmd;
    case (style)
      TRAFFIC_TYPING: begin
        poll_pct = 10;
        busy_pct = 30;
      end
      TRAFFIC_DRAIN: begin
        poll_pct = 85;
        busy_pct = 20;
      end
      default: begin
        poll_pct = 50;
        busy_pct = 30;
      end
    endcase
    cmd = ($urandom_range(99) < poll_pct) ? CMD_POLL : CMD_KEY_SAMPLE;
    // Mostly real keys; a few indexes past the key count are mixed in.
    if ($urandom_range(99) < 12) idx = $urandom_range(127);
    else idx = $urandom_range(KEY_COUNT - 1);
    return make_request(cmd, idx, 1'($urandom_range(1)),
                        $urandom_range(99) < busy_pct);
  endfunction

  task automatic send_request(input in_item_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_for_delivery();
    in_valid <= 1'b0;
    do @(posedge clk); while (codes_awaited != 0);
  endtask

  initial begin
    int       sender_pcts [4];
    int       receiver_pcts [4];
    int       sent;
    int       run_left;
    traffic_t style;
    in_item_t req;

    sender_pcts   = '{0, 60, 0, 29};
    receiver_pcts = '{0, 0, 60, 29};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Make and break codes, no-change samples, out-of-range keys, empty and
    // busy polls, and fields that each request type should ignore.
    send_request(make_request(CMD_KEY_SAMPLE, 0, 1'b1, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 69, 1'b1, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 69, 1'b1, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 0, 1'b0, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 70, 1'b1, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 127, 1'b1, 1'b1));
    send_request(make_request(CMD_KEY_SAMPLE, 127, 1'b0, 1'b0));
    send_request(make_request(CMD_POLL, 0, 1'b0, 1'b1));
    send_request(make_request(CMD_POLL, 0, 1'b0, 1'b0));
    send_request(make_request(CMD_POLL, 0, 1'b0, 1'b0));
    send_request(make_request(CMD_POLL, 0, 1'b0, 1'b0));
    send_request(make_request(CMD_POLL, 0, 1'b0, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 27, 1'b1, 1'b1));
    send_request(make_request(CMD_KEY_SAMPLE, 55, 1'b1, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 66, 1'b1, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 69, 1'b0, 1'b0));
    send_request(make_request(CMD_POLL, 127, 1'b1, 1'b0));
    send_request(make_request(CMD_POLL, 0, 1'b0, 1'b0));
    send_request(make_request(CMD_POLL, 0, 1'b0, 1'b0));
    send_request(make_request(CMD_POLL, 0, 1'b0, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 27, 1'b0, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 55, 1'b0, 1'b0));
    send_request(make_request(CMD_KEY_SAMPLE, 66, 1'b0, 1'b0));
    wait_for_delivery();

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = sender_pcts[phase];
      receiver_stall_pct = receiver_pcts[phase];
      sent     = 0;
      run_left = 0;
      style    = TRAFFIC_MIXED;
      while (sent < PHASE_ITEMS) begin
        // Traffic comes in runs, so typing bursts can overflow the queue and
        // drain runs can empty it again.
        if (run_left == 0) begin
          style    = traffic_t'($urandom_range(2));
          run_left = $urandom_range(48, 16);
        end
        run_left--;
        req = random_request(style);
        send_request(req);
        if (req.cmd == CMD_POLL || req.key_index < KEY_COUNT) sent++;
      end
      wait_for_delivery();
    end

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    in_valid <= 1'b0;
    do @(posedge clk); while (codes_awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
